// ===== rtl/cpu_register_transfer_unit_core_assert.svh =====
// Assertion macros for the register transfer unit core.
`ifndef CPU_REGISTER_TRANSFER_UNIT_CORE_ASSERT_SVH
`define CPU_REGISTER_TRANSFER_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRTU_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crtu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CRTU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crtu: next-cycle check failed");

`endif

// ===== rtl/crtu_pkg.sv =====
// Shared types and constants of the register transfer unit.
package crtu_pkg;

  // Instruction codes
  localparam logic [2:0] CMD_XBA      = 3'd0;
  localparam logic [2:0] CMD_XCE      = 3'd1;
  localparam logic [2:0] CMD_FLAG     = 3'd2;
  localparam logic [2:0] CMD_REPSEP   = 3'd3;
  localparam logic [2:0] CMD_TRANSFER = 3'd4;
  localparam logic [2:0] CMD_TOSTACK  = 3'd5;

  // Register select codes
  localparam logic [2:0] SEL_A = 3'd0;
  localparam logic [2:0] SEL_X = 3'd1;
  localparam logic [2:0] SEL_Y = 3'd2;
  localparam logic [2:0] SEL_S = 3'd3;
  localparam logic [2:0] SEL_D = 3'd4;

  // Status bit positions
  localparam int unsigned P_C = 0;
  localparam int unsigned P_Z = 1;
  localparam int unsigned P_X = 4;
  localparam int unsigned P_M = 5;
  localparam int unsigned P_N = 7;

  // Reset values
  localparam logic [15:0] RST_SP     = 16'h01FF;
  localparam logic [7:0]  RST_STATUS = 8'h34;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] source_sel;
    logic [2:0] dest_sel;
    logic       word_size;
    logic [2:0] flag_index;
    logic       flag_value;
    logic       set_mode;
    logic [7:0] mask;
  } instr_t;

  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] s;
    logic [15:0] d;
    logic [7:0]  p;
    logic        e;
  } regfile_t;

endpackage

// ===== rtl/crtu_exec.sv =====
// Next-state logic of the register file for one register-only instruction.
module crtu_exec (
  input  crtu_pkg::regfile_t cur,
  input  crtu_pkg::instr_t   op,
  output crtu_pkg::regfile_t nxt
);
  import crtu_pkg::*;

  logic        src_ok;
  logic        dst_ok;
  logic [15:0] src_val;
  logic [15:0] dst_val;
  logic [15:0] wval;

  always_comb begin
    src_ok = op.source_sel inside {[SEL_A:SEL_D]};
    dst_ok = op.dest_sel inside {[SEL_A:SEL_D]};

    case (op.source_sel)
      SEL_A:   src_val = cur.acc;
      SEL_X:   src_val = cur.x;
      SEL_Y:   src_val = cur.y;
      SEL_S:   src_val = cur.s;
      SEL_D:   src_val = cur.d;
      default: src_val = '0;
    endcase

    case (op.dest_sel)
      SEL_A:   dst_val = cur.acc;
      SEL_X:   dst_val = cur.x;
      SEL_Y:   dst_val = cur.y;
      SEL_S:   dst_val = cur.s;
      SEL_D:   dst_val = cur.d;
      default: dst_val = '0;
    endcase

    wval = op.word_size ? src_val : {dst_val[15:8], src_val[7:0]};
  end

  always_comb begin
    nxt = cur;
    case (op.cmd)
      CMD_XBA: begin
        nxt.acc    = {cur.acc[7:0], cur.acc[15:8]};
        nxt.p[P_N] = cur.acc[15];
        nxt.p[P_Z] = (cur.acc[15:8] == 8'h00);
      end
      CMD_XCE: begin
        nxt.p[P_C] = cur.e;
        nxt.e      = cur.p[P_C];
        if (cur.p[P_C]) begin
          nxt.p[P_M] = 1'b1;
          nxt.p[P_X] = 1'b1;
          nxt.x      = {8'h00, cur.x[7:0]};
          nxt.y      = {8'h00, cur.y[7:0]};
          nxt.s      = {STACK_PAGE, cur.s[7:0]};
        end
      end
      CMD_FLAG: begin
        nxt.p[op.flag_index] = op.flag_value;
      end
      CMD_REPSEP: begin
        nxt.p = op.set_mode ? (cur.p | op.mask) : (cur.p & ~op.mask);
        if (cur.e) begin
          nxt.p[P_M] = 1'b1;
          nxt.p[P_X] = 1'b1;
        end
        if (nxt.p[P_X]) begin
          nxt.x = {8'h00, cur.x[7:0]};
          nxt.y = {8'h00, cur.y[7:0]};
        end
      end
      CMD_TRANSFER: begin
        if (src_ok && dst_ok) begin
          case (op.dest_sel)
            SEL_A:   nxt.acc = wval;
            SEL_X:   nxt.x   = wval;
            SEL_Y:   nxt.y   = wval;
            SEL_S:   nxt.s   = wval;
            SEL_D:   nxt.d   = wval;
            default: nxt.d   = cur.d;
          endcase
          if (op.word_size) begin
            nxt.p[P_N] = src_val[15];
            nxt.p[P_Z] = (src_val == 16'h0000);
          end else begin
            nxt.p[P_N] = src_val[7];
            nxt.p[P_Z] = (src_val[7:0] == 8'h00);
          end
        end
      end
      CMD_TOSTACK: begin
        if (src_ok) begin
          nxt.s = cur.e ? {cur.s[15:8], src_val[7:0]} : src_val;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

// ===== rtl/cpu_register_transfer_unit_core.sv =====
// Top level of the register transfer unit: input register, state and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | cmd, source_sel, dest_sel, word_size,
//          |                       | flag_index, flag_value, set_mode, mask
//  out     | out_valid / out_stall | acc, index_x, index_y, stack_ptr,
//          |                       | direct_page, status, emulation
//
// Each instruction passes from input transfer to result through the input register,
// then through the next-state logic into the register file. One instruction per
// cycle is sustained while out_stall is low; the register file doubles as the
// result register, so the next instruction reads the state left by the last.
// rst (synchronous) empties both stages and loads the power-on register file.
// out_stall holds the result and the input register; in_stall rises only
// while the input register is full and cannot move on.
module cpu_register_transfer_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [2:0]  source_sel,
  input  logic [2:0]  dest_sel,
  input  logic        word_size,
  input  logic [2:0]  flag_index,
  input  logic        flag_value,
  input  logic        set_mode,
  input  logic [7:0]  mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] acc,
  output logic [15:0] index_x,
  output logic [15:0] index_y,
  output logic [15:0] stack_ptr,
  output logic [15:0] direct_page,
  output logic [7:0]  status,
  output logic        emulation
);
  import crtu_pkg::*;

  // Input register
  logic     in_full;
  instr_t   instr;

  // Architectural registers, presented directly as the result
  regfile_t regs;
  regfile_t regs_next;

  logic     advance;
  logic     fire;

  // Emulation-mode invariants on the presented register file
  logic     emu_entry_ok;

  // Result slot is free, or its transfer completes this cycle
  assign advance  = !out_valid || !out_stall;
  // Execute the held instruction whenever the result slot can take it
  assign fire     = in_full && advance;
  // Stall input only while the held instruction is stuck
  assign in_stall = in_full && !advance;

  crtu_exec u_exec (
    .cur (regs),
    .op  (instr),
    .nxt (regs_next)
  );

  // Input stage: capture a new instruction whenever the stage is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      instr <= '{cmd: cmd, source_sel: source_sel, dest_sel: dest_sel,
                 word_size: word_size, flag_index: flag_index,
                 flag_value: flag_value, set_mode: set_mode, mask: mask};
    end
  end

  // Result valid: set on execute, drop once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Register file: load the power-on values, then advance one instruction
  // per execute and hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{acc: 16'h0000, x: 16'h0000, y: 16'h0000, s: RST_SP,
                d: 16'h0000, p: RST_STATUS, e: 1'b1};
    end else if (fire) begin
      regs <= regs_next;
    end
  end

  assign acc         = regs.acc;
  assign index_x     = regs.x;
  assign index_y     = regs.y;
  assign stack_ptr   = regs.s;
  assign direct_page = regs.d;
  assign status      = regs.p;
  assign emulation   = regs.e;

  assign emu_entry_ok = status[P_M] && status[P_X] && (stack_ptr[15:8] == STACK_PAGE) &&
                        (index_x[15:8] == 8'h00) && (index_y[15:8] == 8'h00);

  `include "cpu_register_transfer_unit_core_assert.svh"

  // A stalled input always means a held instruction
  `CRTU_ASSERT_NOW(a_stall_needs_item, in_stall, in_full)
  // Every executed instruction shows up as a result next cycle
  `CRTU_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)
  // Entering emulation forces M, X, the stack page and clears the index high bytes
  `CRTU_ASSERT_NOW(a_enter_emulation, $rose(emulation), emu_entry_ok)

endmodule

// ===== tb/sv/cpu_register_transfer_unit_core_tb.sv =====
// Self-checking testbench for the register transfer unit core: directed and random instructions.
module cpu_register_transfer_unit_core_tb;
  import crtu_pkg::*;

  // Command and select codes the block treats as no-ops
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam logic [2:0] SEL_BAD_LO  = 3'd5;
  localparam logic [2:0] SEL_BAD_HI  = 3'd7;

  localparam int RANDOM_ITEMS = 530;
  localparam int MAX_GAP      = 16;
  // Long output hold that backs up the pipe into the input.
  localparam int HOLD_CYCLES  = 300;
  // Input register plus register file; allow a few extra cycles at the end.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT   = 3000;

  // Scoreboard: mirror of the architectural registers plus pending results
  class regfile_scoreboard;
    regfile_t arch;
    regfile_t expected_regs[$];
    int       mismatches;
    int       results_seen;
    int       cmd_count[8];

    function new();
      arch.acc   = '0;
      arch.x     = '0;
      arch.y     = '0;
      arch.s     = RST_SP;
      arch.d     = '0;
      arch.p     = RST_STATUS;
      arch.e     = 1'b1;
      mismatches = 0;
      results_seen = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function bit sel_ok(logic [2:0] sel);
      return sel <= SEL_D;
    endfunction

    function logic [15:0] read_reg(logic [2:0] sel);
      case (sel)
        SEL_A:   return arch.acc;
        SEL_X:   return arch.x;
        SEL_Y:   return arch.y;
        SEL_S:   return arch.s;
        default: return arch.d;
      endcase
    endfunction

    function void write_reg(logic [2:0] sel, logic [15:0] value);
      case (sel)
        SEL_A:   arch.acc = value;
        SEL_X:   arch.x   = value;
        SEL_Y:   arch.y   = value;
        SEL_S:   arch.s   = value;
        default: arch.d   = value;
      endcase
    endfunction

    function void set_nz(logic neg, logic zero);
      arch.p[P_N] = neg;
      arch.p[P_Z] = zero;
    endfunction

    function void clear_index_high();
      arch.x[15:8] = 8'h00;
      arch.y[15:8] = 8'h00;
    endfunction

    // Advance the mirror by one instruction and queue the register file it leaves.
    function void note_instr(instr_t ins);
      logic [15:0] v;
      logic [15:0] dv;
      logic [7:0]  lo;
      logic        c;
      cmd_count[ins.cmd]++;
      case (ins.cmd)
        CMD_XBA: begin
          lo = arch.acc[15:8];
          arch.acc = {arch.acc[7:0], lo};
          set_nz(lo[7], lo == 8'h00);
        end
        CMD_XCE: begin
          c = arch.p[P_C];
          arch.p[P_C] = arch.e;
          arch.e = c;
          // Emulation (re)entry forces 8-bit mode and page-one stack
          if (arch.e) begin
            arch.p[P_M] = 1'b1;
            arch.p[P_X] = 1'b1;
            clear_index_high();
            arch.s[15:8] = STACK_PAGE;
          end
        end
        CMD_FLAG: arch.p[ins.flag_index] = ins.flag_value;
        CMD_REPSEP: begin
          arch.p = ins.set_mode ? (arch.p | ins.mask) : (arch.p & ~ins.mask);
          if (arch.e) begin
            arch.p[P_M] = 1'b1;
            arch.p[P_X] = 1'b1;
          end
          if (arch.p[P_X]) clear_index_high();
        end
        CMD_TRANSFER: begin
          if (sel_ok(ins.source_sel) && sel_ok(ins.dest_sel)) begin
            v = read_reg(ins.source_sel);
            if (ins.word_size) begin
              write_reg(ins.dest_sel, v);
              set_nz(v[15], v == 16'h0000);
            end else begin
              dv = read_reg(ins.dest_sel);
              write_reg(ins.dest_sel, {dv[15:8], v[7:0]});
              set_nz(v[7], v[7:0] == 8'h00);
            end
          end
        end
        CMD_TOSTACK: begin
          if (sel_ok(ins.source_sel)) begin
            v = read_reg(ins.source_sel);
            if (arch.e) arch.s[7:0] = v[7:0];
            else arch.s = v;
          end
        end
        default: ;
      endcase
      expected_regs.push_back(arch);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch %0d (result %0d): %s", mismatches, results_seen, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(regfile_t got);
      regfile_t want;
      results_seen++;
      if (expected_regs.size() == 0) begin
        report_mismatch("result with no instruction outstanding");
        return;
      end
      want = expected_regs.pop_front();
      compare_field("acc", got.acc, want.acc);
      compare_field("index_x", got.x, want.x);
      compare_field("index_y", got.y, want.y);
      compare_field("stack_ptr", got.s, want.s);
      compare_field("direct_page", got.d, want.d);
      compare_field("status", {8'h00, got.p}, {8'h00, want.p});
      compare_field("emulation", {15'h0, got.e}, {15'h0, want.e});
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_XBA;
  logic [2:0]  source_sel = SEL_A;
  logic [2:0]  dest_sel = SEL_A;
  logic        word_size = 1'b0;
  logic [2:0]  flag_index = 3'd0;
  logic        flag_value = 1'b0;
  logic        set_mode = 1'b0;
  logic [7:0]  mask = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [15:0] acc;
  logic [15:0] index_x;
  logic [15:0] index_y;
  logic [15:0] stack_ptr;
  logic [15:0] direct_page;
  logic [7:0]  status;
  logic        emulation;

  regfile_scoreboard sb = new();

  // Shared knobs: burst mode turns off idling on both sides; hold_output asks the
  // receiver for one long stall.
  bit burst_mode  = 1'b0;
  bit hold_output = 1'b0;

  cpu_register_transfer_unit_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .source_sel  (source_sel),
    .dest_sel    (dest_sel),
    .word_size   (word_size),
    .flag_index  (flag_index),
    .flag_value  (flag_value),
    .set_mode    (set_mode),
    .mask        (mask),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .acc         (acc),
    .index_x     (index_x),
    .index_y     (index_y),
    .stack_ptr   (stack_ptr),
    .direct_page (direct_page),
    .status      (status),
    .emulation   (emulation)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Random filler for the fields an instruction does not use.
  function automatic instr_t random_fields();
    instr_t ins;
    ins.cmd        = 3'($urandom_range(CMD_XBA, CMD_TOSTACK));
    ins.source_sel = 3'($urandom_range(SEL_A, SEL_D));
    ins.dest_sel   = 3'($urandom_range(SEL_A, SEL_D));
    ins.word_size  = 1'($urandom_range(0, 1));
    ins.flag_index = 3'($urandom_range(0, 7));
    ins.flag_value = 1'($urandom_range(0, 1));
    ins.set_mode   = 1'($urandom_range(0, 1));
    ins.mask       = 8'($urandom_range(0, 255));
    return ins;
  endfunction

  // Mostly legal codes; occasionally reserved commands and bad selects.
  function automatic instr_t random_instr();
    instr_t ins;
    ins = random_fields();
    if ($urandom_range(0, 15) == 0) ins.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    if ($urandom_range(0, 11) == 0) ins.source_sel = 3'($urandom_range(SEL_BAD_LO, SEL_BAD_HI));
    if ($urandom_range(0, 11) == 0) ins.dest_sel = 3'($urandom_range(SEL_BAD_LO, SEL_BAD_HI));
    return ins;
  endfunction

  function automatic instr_t reg_op(logic [2:0] op, logic [2:0] src, logic [2:0] dst,
                                    logic word);
    instr_t ins;
    ins = random_fields();
    ins.cmd        = op;
    ins.source_sel = src;
    ins.dest_sel   = dst;
    ins.word_size  = word;
    return ins;
  endfunction

  function automatic instr_t flag_op(logic [2:0] idx, logic val);
    instr_t ins;
    ins = random_fields();
    ins.cmd        = CMD_FLAG;
    ins.flag_index = idx;
    ins.flag_value = val;
    return ins;
  endfunction

  function automatic instr_t mask_op(logic setm, logic [7:0] m);
    instr_t ins;
    ins = random_fields();
    ins.cmd      = CMD_REPSEP;
    ins.set_mode = setm;
    ins.mask     = m;
    return ins;
  endfunction

  // Offer one instruction and hold it until the block takes it. Called at a clock
  // edge, so each step carries a single assignment to in_valid.
  task automatic send_instr(instr_t ins);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= ins.cmd;
    source_sel <= ins.source_sel;
    dest_sel   <= ins.dest_sel;
    word_size  <= ins.word_size;
    flag_index <= ins.flag_index;
    flag_value <= ins.flag_value;
    set_mode   <= ins.set_mode;
    mask       <= ins.mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles ahead of every result, or one long
  // stretch when asked, then take the result.
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_output) begin
        n = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        n = draw_gap();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Monitor: values read here are the ones the block samples at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_instr({cmd, source_sel, dest_sel, word_size, flag_index, flag_value,
                       set_mode, mask});
      if (out_valid && !out_stall)
        sb.check_result({acc, index_x, index_y, stack_ptr, direct_page, status, emulation});
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  initial begin
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: walk through every command from the power-on state.
    send_instr(reg_op(CMD_XBA, SEL_A, SEL_A, 1'b0));          // swap of zero sets Z
    send_instr(reg_op(CMD_XCE, SEL_A, SEL_A, 1'b0));          // leave emulation, C takes 1
    send_instr(mask_op(1'b0, 8'h30));                         // REP: 16-bit M and X
    send_instr(reg_op(CMD_TRANSFER, SEL_S, SEL_A, 1'b1));     // word S to A
    send_instr(reg_op(CMD_XBA, SEL_A, SEL_A, 1'b0));          // A = FF01, N from high byte
    send_instr(reg_op(CMD_TRANSFER, SEL_A, SEL_X, 1'b1));     // negative word
    send_instr(reg_op(CMD_TRANSFER, SEL_A, SEL_Y, 1'b0));     // byte keeps Y high
    send_instr(reg_op(CMD_TRANSFER, SEL_X, SEL_D, 1'b1));
    send_instr(reg_op(CMD_TRANSFER, SEL_S, SEL_S, 1'b1));     // same source and destination
    send_instr(reg_op(CMD_TRANSFER, SEL_D, SEL_S, 1'b0));     // byte into S sets N/Z
    send_instr(reg_op(CMD_TOSTACK, SEL_A, SEL_X, 1'b0));      // native: full word into S
    send_instr(reg_op(CMD_TOSTACK, SEL_D, SEL_A, 1'b1));      // any source is allowed
    send_instr(flag_op(3'd4, 1'b1));                          // X flag alone keeps high bytes
    send_instr(flag_op(3'd7, 1'b0));
    send_instr(flag_op(3'd0, 1'b1));
    send_instr(mask_op(1'b1, 8'hFF));                         // SEP all: X clears high bytes
    send_instr(mask_op(1'b0, 8'h00));
    send_instr(reg_op(CMD_TRANSFER, SEL_BAD_LO, SEL_BAD_HI, 1'b1)); // bad selects ignored
    send_instr(reg_op(CMD_TOSTACK, 3'd6, SEL_A, 1'b0));
    send_instr(reg_op(CMD_RSVD_LO, SEL_A, SEL_X, 1'b1));
    send_instr(reg_op(CMD_RSVD_HI, SEL_Y, SEL_S, 1'b0));
    send_instr(reg_op(CMD_XCE, SEL_A, SEL_A, 1'b0));          // back to emulation
    send_instr(flag_op(3'd0, 1'b1));
    send_instr(reg_op(CMD_XCE, SEL_A, SEL_A, 1'b0));          // re-entry while already emulating
    send_instr(mask_op(1'b0, 8'hFF));                         // REP in emulation keeps M and X
    send_instr(reg_op(CMD_TOSTACK, SEL_X, SEL_A, 1'b1));      // emulation: low byte only

    // Random: alternate idling and burst stretches, one long output hold midway.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst_mode = ((i / 60) % 3) == 1;
      if (i == 300) hold_output = 1'b1;
      send_instr(random_instr());
    end
    in_valid <= 1'b0;

    while (sb.expected_regs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instructions: xba %0d xce %0d flag %0d rep/sep %0d transfer %0d",
             sb.results_seen, sb.cmd_count[CMD_XBA], sb.cmd_count[CMD_XCE],
             sb.cmd_count[CMD_FLAG], sb.cmd_count[CMD_REPSEP], sb.cmd_count[CMD_TRANSFER]);
    $display("to-stack %0d, reserved %0d, with idle gaps, bursts and a %0d-cycle output hold",
             sb.cmd_count[CMD_TOSTACK], sb.cmd_count[CMD_RSVD_LO] + sb.cmd_count[CMD_RSVD_HI],
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
